// ===== src/q9sd_pkg.sv =====
// Shared constants, node tables and width helpers for the quad9 derivative unit.
package q9sd_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int COORD_W       = 16;
  localparam int DERIV_W       = 18;
  localparam int NODE_W        = 4;
  localparam int NODE_COUNT    = 9;

  localparam logic [NODE_W-1:0] NODE_FIRST = 4'd0;
  localparam logic [NODE_W-1:0] NODE_LAST  = 4'd8;

  localparam int DERIV_MAX = 131071;
  localparam int DERIV_MIN = -131072;

  // Selection codes for the three 1D quadratic factors.
  localparam logic [1:0] L_LO  = 2'd0;
  localparam logic [1:0] L_MID = 2'd1;
  localparam logic [1:0] L_HI  = 2'd2;

  // Stage enables handed to the 1D basis unit.
  typedef struct packed {
    logic ld_prod;
    logic ld_val;
  } q9sd_basis_ctl_t;

  // Width of a coordinate offset or slope: holds -2x, x +/- one.
  function automatic int slope_w(input int frac_bits);
    int w;
    w = frac_bits + 2;
    if (w < 18) begin
      w = 18;
    end
    return w;
  endfunction

  // Width of a rounded 1D basis value.
  function automatic int value_w(input int frac_bits);
    int w;
    w = COORD_W + slope_w(frac_bits) - frac_bits;
    if (w < frac_bits + 2) begin
      w = frac_bits + 2;
    end
    return w + 1;
  endfunction

  // Factor used along xi for each node.
  function automatic logic [1:0] xi_sel(input logic [NODE_W-1:0] k);
    logic [1:0] s;
    case (k)
      4'd0:    s = L_LO;
      4'd1:    s = L_HI;
      4'd2:    s = L_HI;
      4'd3:    s = L_LO;
      4'd4:    s = L_MID;
      4'd5:    s = L_HI;
      4'd6:    s = L_MID;
      4'd7:    s = L_LO;
      default: s = L_MID;
    endcase
    return s;
  endfunction

  // Factor used along eta for each node.
  function automatic logic [1:0] eta_sel(input logic [NODE_W-1:0] k);
    logic [1:0] s;
    case (k)
      4'd0:    s = L_LO;
      4'd1:    s = L_LO;
      4'd2:    s = L_HI;
      4'd3:    s = L_HI;
      4'd4:    s = L_LO;
      4'd5:    s = L_MID;
      4'd6:    s = L_HI;
      4'd7:    s = L_MID;
      default: s = L_MID;
    endcase
    return s;
  endfunction

endpackage

// ===== src/q9sd_basis.sv =====
// Two-stage 1D quadratic Lagrange basis: values and slopes of one coordinate.
module q9sd_basis #(
  parameter int FRAC_BITS = q9sd_pkg::FRAC_BITS_DEF
) (
  input  logic                                                 clk,
  input  q9sd_pkg::q9sd_basis_ctl_t                            ctl,
  input  logic signed [q9sd_pkg::COORD_W-1:0]                  x_i,
  output logic signed [q9sd_pkg::value_w(FRAC_BITS)-1:0]       val_o   [3],
  output logic signed [q9sd_pkg::slope_w(FRAC_BITS)-1:0]       slope_o [3]
);

  localparam int XW = q9sd_pkg::slope_w(FRAC_BITS);
  localparam int VW = q9sd_pkg::value_w(FRAC_BITS);
  localparam int QW = q9sd_pkg::COORD_W + XW;

  localparam logic signed [XW-1:0] ONE_X  = {{(XW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [XW-1:0] HALF_X = {{(XW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [QW-1:0] ONE_Q  = {{(QW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [QW-1:0] HALF_Q = {{(QW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [VW-1:0] ONE_V  = {{(VW-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] xm;
  logic signed [XW-1:0] xp;

  logic signed [QW-1:0] p_lo_r, p_sq_r, p_hi_r;
  logic signed [XW-1:0] x_r;

  logic signed [QW-1:0] adj_lo, adj_hi, adj_sq;
  logic signed [QW-1:0] sh_lo, sh_hi, sh_sq;

  assign xs = XW'(x_i);
  assign xm = xs - ONE_X;
  assign xp = xs + ONE_X;

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      p_lo_r <= QW'(xs) * QW'(xm);
      p_sq_r <= QW'(xs) * QW'(xs);
      p_hi_r <= QW'(xs) * QW'(xp);
      x_r    <= xs;
    end
  end

  // Round to nearest with ties away from zero: add half, less one when negative.
  always_comb begin
    adj_lo = p_lo_r + ONE_Q - QW'({1'b0, p_lo_r[QW-1]});
    adj_hi = p_hi_r + ONE_Q - QW'({1'b0, p_hi_r[QW-1]});
    adj_sq = p_sq_r + HALF_Q;
    sh_lo  = adj_lo >>> (FRAC_BITS + 1);
    sh_hi  = adj_hi >>> (FRAC_BITS + 1);
    sh_sq  = adj_sq >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_val) begin
      val_o[0]   <= sh_lo[VW-1:0];
      val_o[1]   <= ONE_V - sh_sq[VW-1:0];
      val_o[2]   <= sh_hi[VW-1:0];
      slope_o[0] <= x_r - HALF_X;
      slope_o[1] <= -(x_r <<< 1);
      slope_o[2] <= x_r + HALF_X;
    end
  end

endmodule

// ===== src/quad9_shape_derivatives_unit.sv =====
// Top level of the 9-node biquadratic quadrilateral shape derivative unit.
//
// Usage: one request on the in_ channel carries a reference point (xi, eta)
// in signed fixed point with FRAC_BITS fraction bits, plus a batch-end flag.
// For every point the unit sends nine requests on the out_ channel, one per
// node in the order corners, edge midpoints, centre. Each carries the node
// number, dN/dxi and dN/deta (same scaling, saturated to 18 bits), a flag on
// the ninth node and, on that node only, a copy of the batch-end flag.
//
// Each point passes the input register, the basis product and value stages,
// the node serialiser, the node product stage and the output register. The
// single result channel sets throughput; the serialiser reloads on the cycle
// its ninth node moves on, so results flow without gaps while points wait.
// Input and basis stages keep accepting while earlier results are pending.
//
// Reset (rst_n low at a clock edge) empties every stage; no results are
// lost or invented afterwards. When the receiver holds out_ready low the
// output register keeps its request steady, the node pipeline freezes and
// back-pressure reaches in_ready once the basis stages are full.
module quad9_shape_derivatives_unit #(
  parameter int FRAC_BITS = q9sd_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [q9sd_pkg::COORD_W-1:0]  in_xi_coord,
  input  logic signed [q9sd_pkg::COORD_W-1:0]  in_eta_coord,
  input  logic                                 in_final_point,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [q9sd_pkg::NODE_W-1:0]          out_node_index,
  output logic signed [q9sd_pkg::DERIV_W-1:0]  out_deriv_xi,
  output logic signed [q9sd_pkg::DERIV_W-1:0]  out_deriv_eta,
  output logic                                 out_last_node,
  output logic                                 out_point_done_all
);

  localparam int XW = q9sd_pkg::slope_w(FRAC_BITS);
  localparam int VW = q9sd_pkg::value_w(FRAC_BITS);
  localparam int PW = XW + VW;
  localparam int RW = PW + 1;
  localparam int DW = q9sd_pkg::DERIV_W;
  localparam int NW = q9sd_pkg::NODE_W;

  localparam logic signed [RW-1:0] HALF_R = {{(RW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [RW-1:0] MAX_R  = RW'(q9sd_pkg::DERIV_MAX);
  localparam logic signed [RW-1:0] MIN_R  = RW'(q9sd_pkg::DERIV_MIN);

  // Round a node product to FRAC_BITS (ties away from zero) and saturate.
  function automatic logic signed [DW-1:0] rnd_sat(input logic signed [PW-1:0] p);
    logic signed [RW-1:0] adj;
    logic signed [RW-1:0] sh;
    logic signed [DW-1:0] r;
    adj = RW'(p) + HALF_R - RW'({1'b0, p[PW-1]});
    sh  = adj >>> FRAC_BITS;
    if (sh > MAX_R) begin
      r = DW'(q9sd_pkg::DERIV_MAX);
    end else if (sh < MIN_R) begin
      r = DW'(q9sd_pkg::DERIV_MIN);
    end else begin
      r = sh[DW-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Basis pipeline: input register, products, rounded values and slopes.
  // ---------------------------------------------------------------------
  logic                         b1_v_r, b1_v_nxt;
  logic signed [q9sd_pkg::COORD_W-1:0] b1_xi_r, b1_eta_r;
  logic                         b1_fin_r;
  logic                         b2_v_r, b2_v_nxt, b2_fin_r;
  logic                         b3_v_r, b3_v_nxt, b3_fin_r;
  logic                         b1_rdy, b2_rdy, b3_rdy;
  q9sd_pkg::q9sd_basis_ctl_t    bctl;

  logic signed [VW-1:0] vx [3];
  logic signed [XW-1:0] sx [3];
  logic signed [VW-1:0] ve [3];
  logic signed [XW-1:0] se [3];

  // Node serialiser holding one point's factors.
  logic                 ser_v_r, ser_v_nxt;
  logic [NW-1:0]        cnt_r, cnt_nxt;
  logic                 ser_fin_r;
  logic signed [VW-1:0] ser_vx_r [3];
  logic signed [XW-1:0] ser_sx_r [3];
  logic signed [VW-1:0] ser_ve_r [3];
  logic signed [XW-1:0] ser_se_r [3];
  logic                 ser_adv, ser_last, ser_load_ok, ser_load;

  // Node product stage and output register.
  logic                 en;
  logic                 n1_v_r, n1_v_nxt;
  logic signed [PW-1:0] n1_pdxi_r, n1_pdeta_r;
  logic [NW-1:0]        n1_node_r;
  logic                 n1_last_r, n1_fin_r;
  logic                 out_v_r, out_v_nxt;

  logic [1:0]           sel_a, sel_b;
  logic signed [XW-1:0] sx_a, se_b;
  logic signed [VW-1:0] vx_a, ve_b;

  // The whole node pipeline moves together whenever the output can take a step.
  assign en          = !out_v_r || out_ready;
  assign ser_adv     = en && ser_v_r;
  assign ser_last    = (cnt_r == q9sd_pkg::NODE_LAST);
  assign ser_load_ok = !ser_v_r || (ser_adv && ser_last);
  assign ser_load    = b3_v_r && ser_load_ok;

  assign b3_rdy   = !b3_v_r || ser_load_ok;
  assign b2_rdy   = !b2_v_r || b3_rdy;
  assign b1_rdy   = !b1_v_r || b2_rdy;
  assign in_ready = b1_rdy;

  assign bctl.ld_prod = b1_v_r && b2_rdy;
  assign bctl.ld_val  = b2_v_r && b3_rdy;

  always_comb begin
    b1_v_nxt = in_ready ? in_valid : b1_v_r;
    b2_v_nxt = b2_rdy ? b1_v_r : b2_v_r;
    b3_v_nxt = b3_rdy ? b2_v_r : b3_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
    end else begin
      b1_v_r <= b1_v_nxt;
      b2_v_r <= b2_v_nxt;
      b3_v_r <= b3_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      b1_xi_r  <= in_xi_coord;
      b1_eta_r <= in_eta_coord;
      b1_fin_r <= in_final_point;
    end
    if (bctl.ld_prod) begin
      b2_fin_r <= b1_fin_r;
    end
    if (bctl.ld_val) begin
      b3_fin_r <= b2_fin_r;
    end
  end

  q9sd_basis #(
    .FRAC_BITS (FRAC_BITS)
  ) u_basis_xi (
    .clk     (clk),
    .ctl     (bctl),
    .x_i     (b1_xi_r),
    .val_o   (vx),
    .slope_o (sx)
  );

  q9sd_basis #(
    .FRAC_BITS (FRAC_BITS)
  ) u_basis_eta (
    .clk     (clk),
    .ctl     (bctl),
    .x_i     (b1_eta_r),
    .val_o   (ve),
    .slope_o (se)
  );

  // ---------------------------------------------------------------------
  // Serialiser: walks the nine nodes of the held point.
  // ---------------------------------------------------------------------
  always_comb begin
    ser_v_nxt = ser_v_r;
    cnt_nxt   = cnt_r;
    if (ser_load) begin
      ser_v_nxt = 1'b1;
      cnt_nxt   = q9sd_pkg::NODE_FIRST;
    end else if (ser_adv) begin
      if (ser_last) begin
        ser_v_nxt = 1'b0;
      end
      cnt_nxt = cnt_r + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      cnt_r   <= q9sd_pkg::NODE_FIRST;
    end else begin
      ser_v_r <= ser_v_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_vx_r  <= vx;
      ser_sx_r  <= sx;
      ser_ve_r  <= ve;
      ser_se_r  <= se;
      ser_fin_r <= b3_fin_r;
    end
  end

  // Pick the xi and eta factors of the current node.
  always_comb begin
    sel_a = q9sd_pkg::xi_sel(cnt_r);
    sel_b = q9sd_pkg::eta_sel(cnt_r);
    case (sel_a)
      q9sd_pkg::L_LO: begin
        sx_a = ser_sx_r[0];
        vx_a = ser_vx_r[0];
      end
      q9sd_pkg::L_HI: begin
        sx_a = ser_sx_r[2];
        vx_a = ser_vx_r[2];
      end
      default: begin
        sx_a = ser_sx_r[1];
        vx_a = ser_vx_r[1];
      end
    endcase
    case (sel_b)
      q9sd_pkg::L_LO: begin
        se_b = ser_se_r[0];
        ve_b = ser_ve_r[0];
      end
      q9sd_pkg::L_HI: begin
        se_b = ser_se_r[2];
        ve_b = ser_ve_r[2];
      end
      default: begin
        se_b = ser_se_r[1];
        ve_b = ser_ve_r[1];
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Node products, then rounding and saturation into the output register.
  // ---------------------------------------------------------------------
  always_comb begin
    n1_v_nxt  = en ? ser_v_r : n1_v_r;
    out_v_nxt = en ? n1_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      n1_v_r  <= n1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_adv) begin
      n1_pdxi_r  <= PW'(sx_a) * PW'(ve_b);
      n1_pdeta_r <= PW'(vx_a) * PW'(se_b);
      n1_node_r  <= cnt_r;
      n1_last_r  <= ser_last;
      n1_fin_r   <= ser_last && ser_fin_r;
    end
    if (en && n1_v_r) begin
      out_deriv_xi       <= rnd_sat(n1_pdxi_r);
      out_deriv_eta      <= rnd_sat(n1_pdeta_r);
      out_node_index     <= n1_node_r;
      out_last_node      <= n1_last_r;
      out_point_done_all <= n1_fin_r;
    end
  end

  assign out_valid = out_v_r;

endmodule

// ===== src/q9sd_checker.sv =====
// Port-level checker for the quad9 derivative unit, bound to the top level.
module q9sd_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [q9sd_pkg::NODE_W-1:0]          out_node_index,
  input logic signed [q9sd_pkg::DERIV_W-1:0]  out_deriv_xi,
  input logic signed [q9sd_pkg::DERIV_W-1:0]  out_deriv_eta,
  input logic                                 out_last_node,
  input logic                                 out_point_done_all
);

  logic [q9sd_pkg::NODE_W-1:0] exp_r, exp_nxt;

  // Expected node number of the next result taken.
  always_comb begin
    exp_nxt = exp_r;
    if (out_valid && out_ready) begin
      exp_nxt = out_last_node ? q9sd_pkg::NODE_FIRST
                              : out_node_index + q9sd_pkg::NODE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= q9sd_pkg::NODE_FIRST;
    end else begin
      exp_r <= exp_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node_index) &&
      $stable(out_deriv_xi) && $stable(out_deriv_eta) && $stable(out_last_node) &&
      $stable(out_point_done_all))
    else $error("result changed while stalled");

  a_node_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_node_index == exp_r)
    else $error("node results out of order");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_last_node == (out_node_index == q9sd_pkg::NODE_LAST))
    else $error("last-node flag on wrong node");

  a_done_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_node |-> !out_point_done_all)
    else $error("batch-end flag before the last node");

endmodule

bind quad9_shape_derivatives_unit q9sd_checker u_q9sd_checker (.*);

// ===== tb/tb_quad9_shape_derivatives_unit.sv =====
// Self-checking testbench for the quad9 shape derivative unit, with random flow control.
`timescale 1ns / 1ps

module tb_quad9_shape_derivatives_unit;

  localparam int FRAC         = q9sd_pkg::FRAC_BITS_DEF;
  localparam int COORD_W      = q9sd_pkg::COORD_W;
  localparam int NODE_W       = q9sd_pkg::NODE_W;
  localparam int DERIV_W      = q9sd_pkg::DERIV_W;
  localparam int NODE_COUNT   = q9sd_pkg::NODE_COUNT;
  localparam int DERIV_MAX    = q9sd_pkg::DERIV_MAX;
  localparam int DERIV_MIN    = q9sd_pkg::DERIV_MIN;
  localparam int RANDOM_ITEMS = 500;
  // A long receiver stall can sit on top of the unit's delay to its first node,
  // so the idle limit below is generous.
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;

  // One request on the input side: a reference point and its batch-end flag.
  typedef struct packed {
    logic signed [COORD_W-1:0] xi;
    logic signed [COORD_W-1:0] eta;
    logic                      final_point;
  } ref_point_t;

  // One request on the result side: the derivatives of a single node.
  typedef struct packed {
    logic [NODE_W-1:0]         node_index;
    logic signed [DERIV_W-1:0] deriv_xi;
    logic signed [DERIV_W-1:0] deriv_eta;
    logic                      last_node;
    logic                      point_done_all;
  } node_deriv_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid       = 1'b0;
  logic                       in_ready;
  logic signed [COORD_W-1:0]  in_xi_coord    = '0;
  logic signed [COORD_W-1:0]  in_eta_coord   = '0;
  logic                       in_final_point = 1'b0;
  logic                       out_valid;
  logic                       out_ready      = 1'b0;
  logic [NODE_W-1:0]          out_node_index;
  logic signed [DERIV_W-1:0]  out_deriv_xi;
  logic signed [DERIV_W-1:0]  out_deriv_eta;
  logic                       out_last_node;
  logic                       out_point_done_all;

  ref_point_t  pending_points_q[$];
  node_deriv_t expected_nodes_q[$];

  int error_count     = 0;
  int points_total    = 0;
  int points_accepted = 0;
  int nodes_checked   = 0;
  int clipped_derivs  = 0;
  int batch_ends      = 0;
  int idle_cycles     = 0;

  quad9_shape_derivatives_unit #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_xi_coord       (in_xi_coord),
    .in_eta_coord      (in_eta_coord),
    .in_final_point    (in_final_point),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_node_index    (out_node_index),
    .out_deriv_xi      (out_deriv_xi),
    .out_deriv_eta     (out_deriv_eta),
    .out_last_node     (out_last_node),
    .out_point_done_all(out_point_done_all)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor of the node derivatives.
  // ---------------------------------------------------------------------------

  // Divides by 2^s and rounds to nearest, with ties going away from zero.
  function automatic longint round_div_pow2(input longint v, input int s);
    longint mag;
    longint r;
    mag = (v < 0) ? -v : v;
    r = (mag + (longint'(1) << (s - 1))) >>> s;
    return (v < 0) ? -r : r;
  endfunction

  // Value of one of the three 1D quadratic Lagrange factors at x. Each value is
  // rounded once, straight from the exact product.
  function automatic longint lagrange_value(input longint x, input logic [1:0] sel);
    longint one;
    one = longint'(1) << FRAC;
    case (sel)
      q9sd_pkg::L_LO:  return round_div_pow2(x * (x - one), FRAC + 1);
      q9sd_pkg::L_MID: return one - round_div_pow2(x * x, FRAC);
      default:         return round_div_pow2(x * (x + one), FRAC + 1);
    endcase
  endfunction

  // The slopes are exact at the working precision, so there is no rounding here.
  function automatic longint lagrange_slope(input longint x, input logic [1:0] sel);
    longint half;
    half = longint'(1) << (FRAC - 1);
    case (sel)
      q9sd_pkg::L_LO:  return x - half;
      q9sd_pkg::L_MID: return -2 * x;
      default:         return x + half;
    endcase
  endfunction

  // The factors that build each node, packed as {xi factor, eta factor}. The
  // corners come first, then the edge midpoints, then the centre.
  function automatic logic [3:0] node_factors(input int k);
    case (k)
      0:       return {q9sd_pkg::L_LO,  q9sd_pkg::L_LO};
      1:       return {q9sd_pkg::L_HI,  q9sd_pkg::L_LO};
      2:       return {q9sd_pkg::L_HI,  q9sd_pkg::L_HI};
      3:       return {q9sd_pkg::L_LO,  q9sd_pkg::L_HI};
      4:       return {q9sd_pkg::L_MID, q9sd_pkg::L_LO};
      5:       return {q9sd_pkg::L_HI,  q9sd_pkg::L_MID};
      6:       return {q9sd_pkg::L_MID, q9sd_pkg::L_HI};
      7:       return {q9sd_pkg::L_LO,  q9sd_pkg::L_MID};
      default: return {q9sd_pkg::L_MID, q9sd_pkg::L_MID};
    endcase
  endfunction

  function automatic logic signed [DERIV_W-1:0] clip_deriv(input longint v);
    if (v > DERIV_MAX) begin
      clipped_derivs++;
      return DERIV_W'(DERIV_MAX);
    end
    if (v < DERIV_MIN) begin
      clipped_derivs++;
      return DERIV_W'(DERIV_MIN);
    end
    return DERIV_W'(v);
  endfunction

  // Appends the nine node requests that one accepted point must produce.
  function automatic void predict_node_derivs(input ref_point_t p);
    logic [3:0]  sel;
    longint      x;
    longint      e;
    node_deriv_t nd;
    x = longint'(p.xi);
    e = longint'(p.eta);
    for (int k = 0; k < NODE_COUNT; k++) begin
      sel = node_factors(k);
      nd.node_index     = NODE_W'(k);
      nd.deriv_xi       = clip_deriv(round_div_pow2(
          lagrange_slope(x, sel[3:2]) * lagrange_value(e, sel[1:0]), FRAC));
      nd.deriv_eta      = clip_deriv(round_div_pow2(
          lagrange_value(x, sel[3:2]) * lagrange_slope(e, sel[1:0]), FRAC));
      nd.last_node      = (NODE_W'(k) == q9sd_pkg::NODE_LAST);
      nd.point_done_all = nd.last_node & p.final_point;
      expected_nodes_q.push_back(nd);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Idle lengths: mostly none or short, now and then a long pause.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Most coordinates lie in the nominal element, some sit close to its edges or
  // on the half-way points, and the rest use the whole 16-bit range.
  function automatic logic signed [COORD_W-1:0] random_coord();
    int r;
    int c;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      c = int'($urandom_range(0, 32768)) - 16384;
    end else if (r < 75) begin
      c = ($urandom_range(0, 1) ? 16384 : -16384) + int'($urandom_range(0, 64)) - 32;
    end else if (r < 85) begin
      c = (int'($urandom_range(0, 4)) - 2) * 8192 + int'($urandom_range(0, 2)) - 1;
    end else begin
      c = int'($urandom_range(0, 65535)) - 32768;
    end
    return COORD_W'(c);
  endfunction

  function automatic void queue_point(input int xi, input int eta, input logic fin);
    ref_point_t p;
    p.xi          = COORD_W'(xi);
    p.eta         = COORD_W'(eta);
    p.final_point = fin;
    pending_points_q.push_back(p);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. A point stays on the inputs until it is accepted; the prediction is
  // made from the payload at the edge that accepts it. The next point, if one
  // is due without a gap, is loaded at that same edge, so in_valid is never
  // dropped and raised again within one time step.
  // ---------------------------------------------------------------------------
  int   in_gap  = 0;
  logic in_calm = 1'b0;

  always @(posedge clk) begin
    ref_point_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        p.xi          = in_xi_coord;
        p.eta         = in_eta_coord;
        p.final_point = in_final_point;
        predict_node_derivs(p);
        points_accepted++;
        if (p.final_point) begin
          batch_ends++;
        end
        // Now and then switch to a stretch with no gaps at all.
        if (points_accepted % 40 == 0) begin
          in_calm = ($urandom_range(0, 2) == 0);
        end
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_points_q.size() > 0) begin
          p = pending_points_q.pop_front();
          in_xi_coord    <= p.xi;
          in_eta_coord   <= p.eta;
          in_final_point <= p.final_point;
          in_valid       <= 1'b1;
          in_gap = in_calm ? 0 : idle_length();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every accepted node request is compared field by field with the
  // oldest prediction. out_ready is dropped at random to stall the unit.
  // ---------------------------------------------------------------------------
  int   out_stall = 0;
  logic out_calm  = 1'b0;

  always @(posedge clk) begin
    node_deriv_t exp_nd;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_nodes_q.size() == 0) begin
          $error("node request with no point pending: node %0d", out_node_index);
          error_count++;
        end else begin
          exp_nd = expected_nodes_q.pop_front();
          if (out_node_index !== exp_nd.node_index) begin
            $error("node_index: expected %0d, got %0d", exp_nd.node_index, out_node_index);
            error_count++;
          end
          if (out_deriv_xi !== exp_nd.deriv_xi) begin
            $error("deriv_xi (node %0d): expected %0d, got %0d", exp_nd.node_index,
                   $signed(exp_nd.deriv_xi), out_deriv_xi);
            error_count++;
          end
          if (out_deriv_eta !== exp_nd.deriv_eta) begin
            $error("deriv_eta (node %0d): expected %0d, got %0d", exp_nd.node_index,
                   $signed(exp_nd.deriv_eta), out_deriv_eta);
            error_count++;
          end
          if (out_last_node !== exp_nd.last_node) begin
            $error("last_node (node %0d): expected %0b, got %0b", exp_nd.node_index,
                   exp_nd.last_node, out_last_node);
            error_count++;
          end
          if (out_point_done_all !== exp_nd.point_done_all) begin
            $error("point_done_all (node %0d): expected %0b, got %0b", exp_nd.node_index,
                   exp_nd.point_done_all, out_point_done_all);
            error_count++;
          end
        end
        nodes_checked++;
        if (nodes_checked % 90 == 0) begin
          out_calm = ($urandom_range(0, 2) == 0);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_stall = out_calm ? 0 : idle_length();
        out_ready <= (out_stall == 0);
        if (out_stall > 0) begin
          out_stall--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a stretch with no request moving on either side means the unit
  // has hung.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    // Directed points: the centre, the four corners of the element, the edge
    // midpoints, the half-way values, the smallest steps either side of zero
    // (rounding ties) and the coordinate extremes, which drive the derivatives
    // into saturation. The batch-end flag takes both values.
    queue_point(0,      0,      1'b0);
    queue_point(-16384, -16384, 1'b0);
    queue_point(16384,  -16384, 1'b0);
    queue_point(16384,  16384,  1'b1);
    queue_point(-16384, 16384,  1'b0);
    queue_point(0,      -16384, 1'b0);
    queue_point(16384,  0,      1'b1);
    queue_point(8192,   -8192,  1'b0);
    queue_point(-8192,  8192,   1'b0);
    queue_point(1,      -1,     1'b0);
    queue_point(-1,     1,      1'b1);
    queue_point(32767,  32767,  1'b0);
    queue_point(-32768, -32768, 1'b0);
    queue_point(32767,  -32768, 1'b1);
    queue_point(-32768, 32767,  1'b0);
    queue_point(-32768, 0,      1'b0);
    queue_point(0,      32767,  1'b1);
    queue_point(24576,  -24576, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      queue_point(random_coord(), random_coord(), $urandom_range(0, 7) == 0);
    end
    points_total = pending_points_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Every point must have been accepted, and so predicted, before the
    // expected queue can be judged empty.
    while (points_accepted < points_total) begin
      @(posedge clk);
    end
    while (expected_nodes_q.size() != 0) begin
      @(posedge clk);
    end
    // A little longer, so that any surplus node request is still caught.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d points (%0d batch ends) and %0d node requests,", points_accepted,
             batch_ends, nodes_checked);
    $display("of which %0d derivatives were clipped to the 18-bit range.", clipped_derivs);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== quad9_shape_derivatives_unit.f =====
src/q9sd_pkg.sv
src/q9sd_basis.sv
src/quad9_shape_derivatives_unit.sv
src/q9sd_checker.sv
tb/tb_quad9_shape_derivatives_unit.sv
